>>> rtl/eadec_pkg.sv
// ----------------------------------------------------------------------------
// eadec_pkg
// Shared types, command codes and the predictor weight table of the
// block-framed ADPCM decoder.
// ----------------------------------------------------------------------------
package eadec_pkg;

	// Default frame length, in bytes per channel.
	localparam int BYTES_PER_CHANNEL_BLOCK = 15;
	// Default depth of the command queue between front and back.
	localparam int CMD_QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam logic CFG_STEREO_MODE = 1'b0;
	localparam logic CFG_CLIP_ENABLE = 1'b1;

	// Input item kinds.
	localparam logic KIND_BYTE          = 1'b0;
	localparam logic KIND_SECTION_START = 1'b1;

	// Command codes handed from the front to the back.
	localparam logic [2:0] OP_CLEAR     = 3'd0;
	localparam logic [2:0] OP_WEIGHTS   = 3'd1;
	localparam logic [2:0] OP_SHIFTS    = 3'd2;
	localparam logic [2:0] OP_MONO_HDR  = 3'd3;
	localparam logic [2:0] OP_DATA_ST   = 3'd4;
	localparam logic [2:0] OP_DATA_MONO = 3'd5;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] first_sample;
		logic signed [15:0] second_sample;
	} result_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data;
	} cmd_t;

	// Predictor weight table, 20 entries of signed 10-bit values.
	function automatic logic signed [9:0] weight_lookup(input logic [4:0] idx);
		logic signed [9:0] w;
		case (idx)
			5'd1:    w = 10'sd240;
			5'd2:    w = 10'sd460;
			5'd3:    w = 10'sd392;
			5'd6:    w = -10'sd208;
			5'd7:    w = -10'sd220;
			5'd9:    w = 10'sd1;
			5'd10:   w = 10'sd3;
			5'd11:   w = 10'sd4;
			5'd12:   w = 10'sd7;
			5'd13:   w = 10'sd8;
			5'd14:   w = 10'sd10;
			5'd15:   w = 10'sd11;
			5'd17:   w = -10'sd1;
			5'd18:   w = -10'sd3;
			5'd19:   w = -10'sd4;
			default: w = 10'sd0;
		endcase
		return w;
	endfunction

endpackage

>>> rtl/eadec_front.sv
// ----------------------------------------------------------------------------
// eadec_front
// Tracks the byte position inside a block and turns each input item into a
// command for the back: clear, header update or data decode.
// ----------------------------------------------------------------------------
module eadec_front import eadec_pkg::*; #(
	parameter int BYTES_PER_CHANNEL_BLOCK = eadec_pkg::BYTES_PER_CHANNEL_BLOCK
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  stereo_mode,
	input  logic  push,
	input  item_t item,
	output logic  full,
	output logic  cmd_push,
	output cmd_t  cmd,
	input  logic  cmd_full
);

	localparam int POS_W = $clog2(2 * BYTES_PER_CHANNEL_BLOCK);
	localparam int LEN_W = POS_W + 1;
	localparam logic [LEN_W-1:0] LEN_ST   = LEN_W'(2 * BYTES_PER_CHANNEL_BLOCK);
	localparam logic [LEN_W-1:0] LEN_MONO = LEN_W'(BYTES_PER_CHANNEL_BLOCK);

	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] pos_eff;
	logic [LEN_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_next;
	logic             accept;

	assign full     = cmd_full;
	assign accept   = push & ~cmd_full;
	assign cmd_push = accept;

	// A position left over from the other mode starts a new block.
	assign len      = stereo_mode ? LEN_ST : LEN_MONO;
	assign pos_eff  = (LEN_W'(pos_q) >= len) ? '0 : LEN_W'(pos_q);
	assign pos_inc  = pos_eff + LEN_W'(1);
	assign pos_next = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];

	// Classify the request by kind, mode and position.
	always_comb begin
		cmd.data = item.byte_value;
		if (item.kind == KIND_SECTION_START) begin
			cmd.op = OP_CLEAR;
		end else if (stereo_mode) begin
			if (pos_eff == '0) begin
				cmd.op = OP_WEIGHTS;
			end else if (pos_eff == LEN_W'(1)) begin
				cmd.op = OP_SHIFTS;
			end else begin
				cmd.op = OP_DATA_ST;
			end
		end else begin
			cmd.op = (pos_eff == '0) ? OP_MONO_HDR : OP_DATA_MONO;
		end
	end

	// Block position register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= (item.kind == KIND_SECTION_START) ? '0 : pos_next;
		end
	end

endmodule

>>> rtl/eadec_cmd_fifo.sv
// ----------------------------------------------------------------------------
// eadec_cmd_fifo
// Short command queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module eadec_cmd_fifo import eadec_pkg::*; #(
	parameter int DEPTH = eadec_pkg::CMD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_q];

	// Storage; entries carry no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + IDX_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + IDX_W'(1);
			end
			if (do_push & ~do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop & ~do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/eadec_back.sv
// ----------------------------------------------------------------------------
// eadec_back
// Executes commands: keeps per-channel weights, shifts and history, and
// decodes data bytes one sample at a time through a multiply stage and an
// accumulate stage, holding the finished result for the consumer.
// ----------------------------------------------------------------------------
module eadec_back import eadec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    clip_enable,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	output result_t result,
	output logic    result_valid,
	input  logic    result_pop
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]         state_q;
	logic [7:0]         byte_q;
	logic               stereo_q;
	logic               idx_q;
	logic signed [15:0] first_q;
	logic signed [15:0] second_q;
	result_t            out_q;
	logic               out_valid_q;

	logic [31:0]        cur_hist_q [2];
	logic [31:0]        prev_hist_q [2];
	logic signed [9:0]  cur_w_q [2];
	logic signed [9:0]  prev_w_q [2];
	logic [4:0]         shift_q [2];

	logic [31:0]        p_cur_s1;
	logic [31:0]        p_prev_s1;
	logic [31:0]        base_s1;

	logic               ch;
	logic [3:0]         nib;
	logic signed [31:0] p_cur;
	logic signed [31:0] p_prev;
	logic [31:0]        base;
	logic [31:0]        sum;
	logic signed [31:0] scaled;
	logic [31:0]        sample;
	logic               out_free;
	logic               out_write;
	result_t            out_next;

	// Sample selection: the second sample uses the low nibble, and the right
	// channel in stereo.
	assign ch  = idx_q & stereo_q;
	assign nib = idx_q ? byte_q[3:0] : byte_q[7:4];

	// Multiply stage inputs; only the low 32 bits of each product are kept.
	assign p_cur  = $signed(cur_hist_q[ch]) * cur_w_q[ch];
	assign p_prev = $signed(prev_hist_q[ch]) * prev_w_q[ch];
	assign base   = 32'($signed({nib, 28'd0}) >>> shift_q[ch]);

	// Accumulate stage: round, scale down, optionally saturate.
	assign sum    = base_s1 + p_cur_s1 + p_prev_s1 + 32'h0000_0080;
	assign scaled = $signed(sum) >>> 8;
	always_comb begin
		sample = scaled;
		if (clip_enable) begin
			if (scaled < -32'sd32768) begin
				sample = 32'hFFFF_8000;
			end else if (scaled > 32'sd32767) begin
				sample = 32'h0000_7FFF;
			end
		end
	end

	// Result register handshake.
	assign out_free     = ~out_valid_q | result_pop;
	assign cmd_pop      = (state_q == ST_IDLE) & cmd_valid;
	assign result       = out_q;
	assign result_valid = out_valid_q;

	always_comb begin
		out_write = 1'b0;
		out_next  = '{first_sample: first_q, second_sample: second_q};
		if ((state_q == ST_ACC) && idx_q && out_free) begin
			out_write = 1'b1;
			out_next  = '{first_sample: first_q, second_sample: sample[15:0]};
		end else if ((state_q == ST_HOLD) && out_free) begin
			out_write = 1'b1;
		end
	end

	// Multiply pipeline register.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			p_cur_s1  <= p_cur;
			p_prev_s1 <= p_prev;
			base_s1   <= base;
		end
	end

	// Payload registers of the data byte in flight and of the result.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			byte_q   <= cmd.data;
			stereo_q <= (cmd.op == OP_DATA_ST);
		end
		if (state_q == ST_ACC) begin
			if (idx_q) begin
				second_q <= sample[15:0];
			end else begin
				first_q <= sample[15:0];
			end
		end
		if (out_write) begin
			out_q <= out_next;
		end
	end

	// Sequencer and channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				cur_hist_q[c]  <= '0;
				prev_hist_q[c] <= '0;
				cur_w_q[c]     <= '0;
				prev_w_q[c]    <= '0;
				shift_q[c]     <= 5'd8;
			end
		end else begin
			if (out_write) begin
				out_valid_q <= 1'b1;
			end else if (result_pop) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_CLEAR: begin
								for (int c = 0; c < 2; c++) begin
									cur_hist_q[c]  <= '0;
									prev_hist_q[c] <= '0;
								end
							end
							OP_WEIGHTS: begin
								cur_w_q[0]  <= weight_lookup({1'b0, cmd.data[7:4]});
								prev_w_q[0] <= weight_lookup({1'b0, cmd.data[7:4]} + 5'd4);
								cur_w_q[1]  <= weight_lookup({1'b0, cmd.data[3:0]});
								prev_w_q[1] <= weight_lookup({1'b0, cmd.data[3:0]} + 5'd4);
							end
							OP_SHIFTS: begin
								shift_q[0] <= {1'b0, cmd.data[7:4]} + 5'd8;
								shift_q[1] <= {1'b0, cmd.data[3:0]} + 5'd8;
							end
							OP_MONO_HDR: begin
								cur_w_q[0]  <= weight_lookup({1'b0, cmd.data[7:4]});
								prev_w_q[0] <= weight_lookup({1'b0, cmd.data[7:4]} + 5'd4);
								shift_q[0]  <= {1'b0, cmd.data[3:0]} + 5'd8;
							end
							OP_DATA_ST, OP_DATA_MONO: begin
								idx_q   <= 1'b0;
								state_q <= ST_MUL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					prev_hist_q[ch] <= cur_hist_q[ch];
					cur_hist_q[ch]  <= sample;
					if (!idx_q) begin
						idx_q   <= 1'b1;
						state_q <= ST_MUL;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/ea_adpcm_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// ea_adpcm_block_decoder_unit
// Block-framed ADPCM decoder: one compressed byte per request in, one pair of
// 16-bit samples out for every data byte.
//
//   Channel   Handshake             Payload
//   item      push / full           item_t   (kind, byte_value)
//   result    empty / pop           result_t (first_sample, second_sample)
//   config    cfg_we                cfg_index, cfg_data
//
// A header byte or a section start is executed by the back while it is idle;
// a data byte is taken as a command, then each of its samples passes the
// shared multiply stage followed by the accumulate stage, and the second
// sample depends on the first in mono.
// Reset sets weights to zero, shifts to eight and histories to zero at once.
// When the command queue fills, full rises; a result waiting in the output
// register stalls only the back, and the front keeps taking requests.
// ----------------------------------------------------------------------------
module ea_adpcm_block_decoder_unit import eadec_pkg::*; #(
	parameter int BYTES_PER_CHANNEL_BLOCK = eadec_pkg::BYTES_PER_CHANNEL_BLOCK,
	parameter int CMD_QUEUE_DEPTH         = eadec_pkg::CMD_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   item,
	output logic    full,
	output logic    empty,
	input  logic    pop,
	output result_t result,
	input  logic    cfg_we,
	input  logic    cfg_index,
	input  logic    cfg_data
);

	logic    stereo_mode_q;
	logic    clip_enable_q;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    result_valid;
	logic    result_pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= 1'b1;
			clip_enable_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEREO_MODE: stereo_mode_q <= cfg_data;
				CFG_CLIP_ENABLE: clip_enable_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Result queue view.
	assign empty      = ~result_valid;
	assign result_pop = pop & result_valid;

	eadec_front #(
		.BYTES_PER_CHANNEL_BLOCK(BYTES_PER_CHANNEL_BLOCK)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stereo_mode(stereo_mode_q),
		.push       (push),
		.item       (item),
		.full       (full),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.cmd_full   (cmd_full)
	);

	eadec_cmd_fifo #(
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.dout  (cmd_out),
		.empty (cmd_empty)
	);

	eadec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clip_enable (clip_enable_q),
		.cmd_valid   (~cmd_empty),
		.cmd         (cmd_out),
		.cmd_pop     (cmd_pop),
		.result      (result),
		.result_valid(result_valid),
		.result_pop  (result_pop)
	);

endmodule
